// ----- src/mbc_pkg.sv -----
// shared types, codes and sequencer control program for the microprogrammed computer
`default_nettype none

package mbc_pkg;

    // fixed field widths
    localparam int REQ_W        = 2;
    localparam int LOAD_ADDR_W  = 11;
    localparam int LOAD_DATA_W  = 20;
    localparam int WORD_W       = 16;
    localparam int IN_TDATA_W   = 32;

    // parameter defaults
    localparam int MEM_ADDR_BITS_DEF  = 11;
    localparam int CTRL_ADDR_BITS_DEF = 7;

    // request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_LD_CS  = 2'd0,
        REQ_LD_MEM = 2'd1,
        REQ_STEP   = 2'd2,
        REQ_RESET  = 2'd3
    } t_req;

    // F1 field
    localparam logic [2:0] F1_NOP   = 3'd0;
    localparam logic [2:0] F1_ADD   = 3'd1;
    localparam logic [2:0] F1_CLRAC = 3'd2;
    localparam logic [2:0] F1_INCAC = 3'd3;
    localparam logic [2:0] F1_DRTAC = 3'd4;
    localparam logic [2:0] F1_DRTAR = 3'd5;
    localparam logic [2:0] F1_PCTAR = 3'd6;
    localparam logic [2:0] F1_WRITE = 3'd7;

    // F2 field
    localparam logic [2:0] F2_NOP   = 3'd0;
    localparam logic [2:0] F2_SUB   = 3'd1;
    localparam logic [2:0] F2_OR    = 3'd2;
    localparam logic [2:0] F2_AND   = 3'd3;
    localparam logic [2:0] F2_READ  = 3'd4;
    localparam logic [2:0] F2_ACTDR = 3'd5;
    localparam logic [2:0] F2_INCDR = 3'd6;
    localparam logic [2:0] F2_PCTDR = 3'd7;

    // F3 field
    localparam logic [2:0] F3_NOP   = 3'd0;
    localparam logic [2:0] F3_XOR   = 3'd1;
    localparam logic [2:0] F3_COM   = 3'd2;
    localparam logic [2:0] F3_SHL   = 3'd3;
    localparam logic [2:0] F3_SHR   = 3'd4;
    localparam logic [2:0] F3_INCPC = 3'd5;
    localparam logic [2:0] F3_ARTPC = 3'd6;
    localparam logic [2:0] F3_NOP7  = 3'd7;

    // condition select
    localparam logic [1:0] CD_U = 2'd0;
    localparam logic [1:0] CD_I = 2'd1;
    localparam logic [1:0] CD_S = 2'd2;
    localparam logic [1:0] CD_Z = 2'd3;

    // branch kind
    localparam logic [1:0] BR_JMP  = 2'd0;
    localparam logic [1:0] BR_CALL = 2'd1;
    localparam logic [1:0] BR_RET  = 2'd2;
    localparam logic [1:0] BR_MAP  = 2'd3;

    // opcode extraction for MAP
    localparam logic [WORD_W-1:0] OPC_MASK  = 16'h000F;
    localparam int                MAP_SHIFT = 2;

    // sequencer micro-operations
    typedef enum logic [2:0] {
        UOP_NONE,
        UOP_LD_CS,
        UOP_LD_MEM,
        UOP_EXEC,
        UOP_FETCH,
        UOP_RESET
    } t_uop;

    localparam int UPC_W = 3;

    // one sequencer control word
    typedef struct packed {
        t_uop             uop;
        logic             resp;      // deliver a result item
        logic             last;      // back to idle after this word
        logic             jmp_halt;  // jump to target when the machine halts
        logic [UPC_W-1:0] target;
    } t_ctl;

    // program addresses
    localparam logic [UPC_W-1:0] UPC_LD_CS  = 3'd0;
    localparam logic [UPC_W-1:0] UPC_LD_MEM = 3'd1;
    localparam logic [UPC_W-1:0] UPC_EXEC   = 3'd2;
    localparam logic [UPC_W-1:0] UPC_FETCH  = 3'd3;
    localparam logic [UPC_W-1:0] UPC_HALTED = 3'd4;
    localparam logic [UPC_W-1:0] UPC_RESET  = 3'd5;

    function automatic t_ctl ctl_rom(input logic [UPC_W-1:0] upc);
        t_ctl c;
        c = '{uop: UOP_NONE, resp: 1'b1, last: 1'b1, jmp_halt: 1'b0, target: UPC_LD_CS};
        unique case (upc)
            UPC_LD_CS:  c.uop = UOP_LD_CS;
            UPC_LD_MEM: c.uop = UOP_LD_MEM;
            UPC_EXEC: begin
                c.uop      = UOP_EXEC;
                c.resp     = 1'b0;
                c.last     = 1'b0;
                c.jmp_halt = 1'b1;
                c.target   = UPC_HALTED;
            end
            UPC_FETCH:  c.uop = UOP_FETCH;
            UPC_HALTED: c.uop = UOP_NONE;
            UPC_RESET:  c.uop = UOP_RESET;
            default:    c.uop = UOP_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [UPC_W-1:0] entry_of(input t_req req);
        logic [UPC_W-1:0] a;
        unique case (req)
            REQ_LD_CS:  a = UPC_LD_CS;
            REQ_LD_MEM: a = UPC_LD_MEM;
            REQ_STEP:   a = UPC_EXEC;
            REQ_RESET:  a = UPC_RESET;
            default:    a = UPC_HALTED;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ----- src/mbc_seq.sv -----
// request sequencer: step counter over the control program in the package
`default_nettype none

module mbc_seq
    import mbc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_req i_req,
    input  wire logic i_out_free,
    input  wire logic i_halt_next,
    output logic      o_idle,
    output t_ctl      o_ctl,
    output logic      o_fire
);

    logic             r_busy, n_busy;
    logic [UPC_W-1:0] r_upc, n_upc;

    assign o_ctl  = ctl_rom(r_upc);
    assign o_idle = !r_busy;
    // a word with a result waits for room in the output register
    assign o_fire = r_busy && (!o_ctl.resp || i_out_free);

    always_comb begin
        n_busy = r_busy;
        n_upc  = r_upc;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_upc  = entry_of(i_req);
            end
        end else if (o_fire) begin
            if (o_ctl.last) begin
                n_busy = 1'b0;
            end else if (o_ctl.jmp_halt && i_halt_next) begin
                n_upc = o_ctl.target;
            end else begin
                n_upc = r_upc + UPC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_upc  <= UPC_LD_CS;
        end else begin
            r_busy <= n_busy;
            r_upc  <= n_upc;
        end
    end

endmodule

`default_nettype wire

// ----- src/microprogrammed_basic_computer_unit.sv -----
// top level of the microprogrammed basic computer: stores, registers, step datapath
`default_nettype none

// channel  | direction | tdata (lsb first)                            | tuser
// ---------+-----------+----------------------------------------------+---------
// s_axis   | in        | load_address, load_data, zero pad to 32      | req_type
// m_axis   | out       | ac, dr, ar, pc, car, e, i, halted, zero pad  | -
//
// one request at a time. loads and reset emit from their own word; a step runs
// accept, execute, fetch: the main memory read at AR finishes in the accept cycle,
// the execute cycle applies F1/F2/F3 and the branch and reads the control store,
// and the fetch cycle loads the microinstruction register and emits the item.
// the result sits in an output register, so a new request is taken while it waits.
// reset (i_rst_n, synchronous) clears the machine registers; the stores are kept.

module microprogrammed_basic_computer_unit
    import mbc_pkg::*;
#(
    parameter int MEM_ADDR_BITS  = MEM_ADDR_BITS_DEF,
    parameter int CTRL_ADDR_BITS = CTRL_ADDR_BITS_DEF,
    localparam int MAW      = MEM_ADDR_BITS,
    localparam int CAW      = CTRL_ADDR_BITS,
    localparam int OUT_RAW  = 2 * WORD_W + 2 * MAW + CAW + 3,
    localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // load_address [10:0], load_data [30:11]
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    // req_type [1:0]
    input  wire logic [REQ_W-1:0]      s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // ac_value, dr_value, ar_value, pc_value, car_value, e_value, i_value, halted_flag
    output logic [OUT_W-1:0]           m_axis_tdata
);

    localparam int MI_W     = CAW + 13;
    localparam int MEM_D    = 1 << MAW;
    localparam int CS_D     = 1 << CAW;
    localparam int CarRst   = 1 << (CAW - 1);
    localparam logic [CAW-1:0]    CAR_RST = CAW'(CarRst);
    localparam logic [MI_W-1:0]   MI_RST  =
        MI_W'((6 << (CAW + 10)) | ((CarRst + 1) % CS_D));
    localparam logic [WORD_W-1:0] PC_MASK16 = WORD_W'((1 << MAW) - 1);

    // ------------------------------------------------------------------
    // stores
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] r_mem [MEM_D];
    logic [MI_W-1:0]   r_cs  [CS_D];
    logic [WORD_W-1:0] r_mem_rdata;
    logic [MI_W-1:0]   r_cs_rdata;

    // ------------------------------------------------------------------
    // machine registers
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] r_ac,  n_ac;
    logic [WORD_W-1:0] r_dr,  n_dr;
    logic [MAW-1:0]    r_ar,  n_ar;
    logic [MAW-1:0]    r_pc,  n_pc;
    logic [CAW-1:0]    r_car, n_car;
    logic [CAW-1:0]    r_sbr, n_sbr;
    logic              r_e,   n_e;
    logic              r_i,   n_i;
    logic [MI_W-1:0]   r_mi,  n_mi;
    logic              r_halt, n_halt;

    // latched request payload
    logic [LOAD_ADDR_W-1:0] r_laddr;
    logic [LOAD_DATA_W-1:0] r_ldata;

    // output register
    logic             r_o_valid;
    logic [OUT_W-1:0] r_o_data;
    logic             out_free;

    // sequencer
    t_ctl ctl;
    logic fire;
    logic seq_idle;
    logic accept;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = seq_idle;
    assign out_free      = !r_o_valid || m_axis_tready;
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

    mbc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_req       (t_req'(s_axis_tuser)),
        .i_out_free  (out_free),
        .i_halt_next (n_halt),
        .o_idle      (seq_idle),
        .o_ctl       (ctl),
        .o_fire      (fire)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_laddr <= s_axis_tdata[LOAD_ADDR_W-1:0];
            r_ldata <= s_axis_tdata[LOAD_ADDR_W+LOAD_DATA_W-1:LOAD_ADDR_W];
        end
    end

    // ------------------------------------------------------------------
    // load address decode: out-of-range addresses are dropped
    // ------------------------------------------------------------------
    logic [LOAD_ADDR_W+MAW-1:0]  mem_la_ext;
    logic [LOAD_ADDR_W+CAW-1:0]  cs_la_ext;
    logic [LOAD_DATA_W+MI_W-1:0] ld_ext;
    logic                        mem_la_ok, cs_la_ok;

    assign mem_la_ext = (LOAD_ADDR_W + MAW)'(r_laddr);
    assign cs_la_ext  = (LOAD_ADDR_W + CAW)'(r_laddr);
    assign ld_ext     = (LOAD_DATA_W + MI_W)'(r_ldata);
    assign mem_la_ok  = (mem_la_ext >> MAW) == '0;
    assign cs_la_ok   = (cs_la_ext >> CAW) == '0;

    // ------------------------------------------------------------------
    // microinstruction fields
    // ------------------------------------------------------------------
    logic [2:0]     f1, f2, f3;
    logic [1:0]     cd, br;
    logic [CAW-1:0] ad;

    assign f1 = r_mi[CAW+12:CAW+10];
    assign f2 = r_mi[CAW+9:CAW+7];
    assign f3 = r_mi[CAW+6:CAW+4];
    assign cd = r_mi[CAW+3:CAW+2];
    assign br = r_mi[CAW+1:CAW];
    assign ad = r_mi[CAW-1:0];

    // ------------------------------------------------------------------
    // step datapath: every operation sees the registers from before the
    // step, later fields override earlier ones
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] x_ac, x_dr;
    logic [MAW-1:0]    x_ar, x_pc;
    logic [CAW-1:0]    x_car, x_sbr, car_inc;
    logic              x_e, x_i, x_halt, x_wr;
    logic              halt_hit, cond;
    logic [WORD_W:0]   sum_add, sum_sub;
    logic [WORD_W-1:0] dr_neg, map_op, map_car16;

    assign dr_neg    = WORD_W'(~r_dr + WORD_W'(1));
    assign sum_add   = {1'b0, r_ac} + {1'b0, r_dr};
    assign sum_sub   = {1'b0, r_ac} + {1'b0, dr_neg};
    assign car_inc   = r_car + CAW'(1);
    assign map_op    = (r_dr >> MAW) & OPC_MASK;
    assign map_car16 = map_op << MAP_SHIFT;
    assign halt_hit  = (f1 == F1_DRTAR) && (r_dr[MAW-1:0] == '1);

    always_comb begin
        x_ac   = r_ac;
        x_dr   = r_dr;
        x_ar   = r_ar;
        x_pc   = r_pc;
        x_car  = r_car;
        x_sbr  = r_sbr;
        x_e    = r_e;
        x_i    = r_i;
        x_halt = r_halt;
        x_wr   = 1'b0;
        cond   = 1'b1;

        // a halted machine ignores steps
        if (!r_halt) begin
            unique case (f1)
                F1_ADD: begin
                    x_ac = sum_add[WORD_W-1:0];
                    x_e  = sum_add[WORD_W];
                end
                F1_CLRAC: x_ac = '0;
                F1_INCAC: x_ac = r_ac + WORD_W'(1);
                F1_DRTAC: x_ac = r_dr;
                F1_DRTAR: x_ar = r_dr[MAW-1:0];
                F1_PCTAR: x_ar = r_pc;
                F1_WRITE: x_wr = 1'b1;
                default:  ;
            endcase

            if (halt_hit) begin
                // AR all ones stops the machine, nothing else of the step runs
                x_halt = 1'b1;
            end else begin
                unique case (f2)
                    F2_SUB: begin
                        x_ac = sum_sub[WORD_W-1:0];
                        x_e  = sum_sub[WORD_W];
                    end
                    F2_OR:    x_ac = r_ac | r_dr;
                    F2_AND:   x_ac = r_ac & r_dr;
                    // a write in the same step lands first, so the read returns DR
                    F2_READ:  x_dr = (f1 == F1_WRITE) ? r_dr : r_mem_rdata;
                    F2_ACTDR: x_dr = r_ac;
                    F2_INCDR: x_dr = r_dr + WORD_W'(1);
                    F2_PCTDR: x_dr = (r_dr & ~PC_MASK16) | WORD_W'(r_pc);
                    default:  ;
                endcase

                unique case (f3)
                    F3_XOR: x_ac = r_ac ^ r_dr;
                    F3_COM: x_ac = ~r_ac;
                    F3_SHL: begin
                        x_ac = {r_ac[WORD_W-2:0], r_e};
                        x_e  = r_ac[WORD_W-1];
                    end
                    F3_SHR: begin
                        x_ac = {r_e, r_ac[WORD_W-1:1]};
                        x_e  = r_ac[0];
                    end
                    F3_INCPC: x_pc = r_pc + MAW'(1);
                    F3_ARTPC: x_pc = r_ar;
                    default:  ;
                endcase

                unique case (cd)
                    CD_U:    cond = 1'b1;
                    CD_I:    cond = r_i;
                    CD_S:    cond = r_ac[WORD_W-1];
                    CD_Z:    cond = (r_ac == '0);
                    default: cond = 1'b1;
                endcase

                unique case (br)
                    BR_JMP:  x_car = cond ? ad : car_inc;
                    BR_CALL: begin
                        if (cond) begin
                            x_sbr = car_inc;
                            x_car = ad;
                        end else begin
                            x_car = car_inc;
                        end
                    end
                    BR_RET:  x_car = r_sbr;
                    BR_MAP: begin
                        x_i   = r_dr[WORD_W-1];
                        x_car = map_car16[CAW-1:0];
                    end
                    default: x_car = car_inc;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // register update by sequencer word
    // ------------------------------------------------------------------
    always_comb begin
        n_ac   = r_ac;
        n_dr   = r_dr;
        n_ar   = r_ar;
        n_pc   = r_pc;
        n_car  = r_car;
        n_sbr  = r_sbr;
        n_e    = r_e;
        n_i    = r_i;
        n_mi   = r_mi;
        n_halt = r_halt;
        if (fire) begin
            unique case (ctl.uop)
                UOP_EXEC: begin
                    n_ac   = x_ac;
                    n_dr   = x_dr;
                    n_ar   = x_ar;
                    n_pc   = x_pc;
                    n_car  = x_car;
                    n_sbr  = x_sbr;
                    n_e    = x_e;
                    n_i    = x_i;
                    n_halt = x_halt;
                end
                UOP_FETCH: begin
                    if (!r_halt) begin
                        n_mi = r_cs_rdata;
                    end
                end
                UOP_RESET: begin
                    n_ac   = '0;
                    n_dr   = '0;
                    n_ar   = '0;
                    n_pc   = '0;
                    n_car  = CAR_RST;
                    n_sbr  = '0;
                    n_e    = 1'b0;
                    n_i    = 1'b0;
                    n_mi   = MI_RST;
                    n_halt = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac   <= '0;
            r_dr   <= '0;
            r_ar   <= '0;
            r_pc   <= '0;
            r_car  <= CAR_RST;
            r_sbr  <= '0;
            r_e    <= 1'b0;
            r_i    <= 1'b0;
            r_mi   <= MI_RST;
            r_halt <= 1'b0;
        end else begin
            r_ac   <= n_ac;
            r_dr   <= n_dr;
            r_ar   <= n_ar;
            r_pc   <= n_pc;
            r_car  <= n_car;
            r_sbr  <= n_sbr;
            r_e    <= n_e;
            r_i    <= n_i;
            r_mi   <= n_mi;
            r_halt <= n_halt;
        end
    end

    // ------------------------------------------------------------------
    // main memory: one write port (load or WRITE), registered read at AR
    // ------------------------------------------------------------------
    logic              mem_we;
    logic [MAW-1:0]    mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ar;
        mem_wdata = r_dr;
        if (fire && (ctl.uop == UOP_LD_MEM)) begin
            mem_we    = mem_la_ok;
            mem_waddr = mem_la_ext[MAW-1:0];
            mem_wdata = r_ldata[WORD_W-1:0];
        end else if (fire && (ctl.uop == UOP_EXEC)) begin
            mem_we = x_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_rdata <= r_mem[r_ar];
    end

    // ------------------------------------------------------------------
    // control store: loads write, execute reads at the next CAR
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (fire && (ctl.uop == UOP_LD_CS) && cs_la_ok) begin
            r_cs[cs_la_ext[CAW-1:0]] <= ld_ext[MI_W-1:0];
        end
        if (fire && (ctl.uop == UOP_EXEC)) begin
            r_cs_rdata <= r_cs[n_car];
        end
    end

    // ------------------------------------------------------------------
    // output register: snapshot of the registers after the request
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (fire && ctl.resp) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && ctl.resp) begin
            r_o_data <= OUT_W'({n_halt, n_i, n_e, n_car, n_pc, n_ar, n_dr, n_ac});
        end
    end

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// testbench for the microprogrammed basic computer unit: directed and random requests checked against a predictor
`timescale 1ns / 100ps

module testbench
    import mbc_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_GOAL   = 1900;

    // one request as offered on the input channel
    typedef struct {
        t_req        kind;
        logic [10:0] addr;
        logic [19:0] data;
    } t_req_item;

    // machine registers as reported in one result item
    typedef struct {
        logic [15:0] ac;
        logic [15:0] dr;
        logic [10:0] ar;
        logic [10:0] pc;
        logic [6:0]  car;
        logic        e;
        logic        i;
        logic        halted;
    } t_cpu_view;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // load_address [10:0], load_data [30:11], zero [31]
    logic [1:0]  s_axis_tuser;   // req_type [1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // ac, dr, ar, pc, car, e, i, halted

    microprogrammed_basic_computer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predicted machine state
    logic [15:0] m_ac, m_dr;
    logic [10:0] m_ar, m_pc;
    logic [6:0]  m_car, m_sbr;
    logic        m_e, m_i, m_halt;
    logic [19:0] m_mi;
    logic [19:0] cs_word [0:127];
    logic [15:0] mem_word [0:2047];
    bit          cs_ok [0:127];
    bit          mem_ok [0:2047];

    t_req_item req_backlog [$];
    t_cpu_view due_views [$];

    int n_real, n_steps, n_loads, n_resets, n_halts;
    int n_bad, n_taken, cycles;
    logic in_fire, rx_hold, calm;

    // no idling on either side inside this window
    assign calm = (cycles >= 3000) && (cycles < 6000);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic void machine_clear();
        m_ac   = '0;
        m_dr   = '0;
        m_ar   = '0;
        m_pc   = '0;
        m_car  = 7'd64;
        m_sbr  = '0;
        m_e    = 1'b0;
        m_i    = 1'b0;
        m_halt = 1'b0;
        // power-up microinstruction: PCTAR, jump to 65
        m_mi   = {F1_PCTAR, F2_NOP, F3_NOP, CD_U, BR_JMP, 7'd65};
    endfunction

    function automatic logic [19:0] uword(logic [2:0] f1, logic [2:0] f2, logic [2:0] f3,
                                          logic [1:0] cd, logic [1:0] br, logic [6:0] ad);
        return {f1, f2, f3, cd, br, ad};
    endfunction

    // condition selected by the current microinstruction, on pre-step values
    function automatic logic cond_holds();
        case (m_mi[10:9])
            CD_U:    return 1'b1;
            CD_I:    return m_i;
            CD_S:    return m_ac[15];
            default: return m_ac == 16'd0;
        endcase
    endfunction

    // control address the current microinstruction moves to
    function automatic logic [6:0] branch_target();
        logic [6:0] seq;
        seq = m_car + 7'd1;
        case (m_mi[8:7])
            BR_JMP, BR_CALL: return cond_holds() ? m_mi[6:0] : seq;
            BR_RET:          return m_sbr;
            default:         return {1'b0, m_dr[14:11], 2'b00};
        endcase
    endfunction

    function automatic logic will_halt();
        return (m_mi[19:17] == F1_DRTAR) && (&m_dr[10:0]);
    endfunction

    // one microinstruction: every field reads pre-step values, later field wins
    function automatic void exec_micro();
        logic [15:0] ac, dr, neg;
        logic [10:0] ar, pc;
        logic [6:0]  tgt, seq;
        logic        e, call;
        ac   = m_ac;
        dr   = m_dr;
        ar   = m_ar;
        pc   = m_pc;
        e    = m_e;
        tgt  = branch_target();
        seq  = m_car + 7'd1;
        call = (m_mi[8:7] == BR_CALL) && cond_holds();
        neg  = ~dr + 16'd1;

        case (m_mi[19:17])
            F1_ADD:   {m_e, m_ac} = {1'b0, ac} + {1'b0, dr};
            F1_CLRAC: m_ac = '0;
            F1_INCAC: m_ac = ac + 16'd1;
            F1_DRTAC: m_ac = dr;
            F1_DRTAR: begin
                m_ar = dr[10:0];
                if (&dr[10:0]) begin
                    // address register all ones stops the machine mid-step
                    m_halt = 1'b1;
                    n_halts++;
                    return;
                end
            end
            F1_PCTAR: m_ar = pc;
            F1_WRITE: begin
                mem_word[ar] = dr;
                mem_ok[ar]   = 1'b1;
            end
            default: ;
        endcase

        case (m_mi[16:14])
            F2_SUB:   {m_e, m_ac} = {1'b0, ac} + {1'b0, neg};
            F2_OR:    m_ac = ac | dr;
            F2_AND:   m_ac = ac & dr;
            F2_READ:  m_dr = mem_word[ar];
            F2_ACTDR: m_dr = ac;
            F2_INCDR: m_dr = dr + 16'd1;
            F2_PCTDR: m_dr = {dr[15:11], pc};
            default: ;
        endcase

        case (m_mi[13:11])
            F3_XOR:   m_ac = ac ^ dr;
            F3_COM:   m_ac = ~ac;
            F3_SHL: begin
                m_ac = {ac[14:0], e};
                m_e  = ac[15];
            end
            F3_SHR: begin
                m_ac = {e, ac[15:1]};
                m_e  = ac[0];
            end
            F3_INCPC: m_pc = pc + 11'd1;
            F3_ARTPC: m_pc = ar;
            default: ;
        endcase

        if (call)
            m_sbr = seq;
        if (m_mi[8:7] == BR_MAP)
            m_i = dr[15];
        m_car = tgt;
        m_mi  = cs_word[tgt];
    endfunction

    // apply one request to the predicted machine and queue it with its result
    function automatic void push_item(t_req kind, logic [10:0] addr, logic [19:0] data);
        t_req_item it;
        t_cpu_view v;
        it.kind = kind;
        it.addr = addr;
        it.data = data;
        req_backlog.insert(req_backlog.size(), it);

        case (kind)
            REQ_LD_CS: begin
                n_loads++;
                if (addr < 11'd128) begin
                    cs_word[addr[6:0]] = data;
                    cs_ok[addr[6:0]]   = 1'b1;
                    n_real++;
                end
            end
            REQ_LD_MEM: begin
                n_loads++;
                n_real++;
                mem_word[addr] = data[15:0];
                mem_ok[addr]   = 1'b1;
            end
            REQ_STEP: begin
                n_steps++;
                if (!m_halt) begin
                    n_real++;
                    exec_micro();
                end
            end
            default: begin
                n_resets++;
                n_real++;
                machine_clear();
            end
        endcase

        v.ac     = m_ac;
        v.dr     = m_dr;
        v.ar     = m_ar;
        v.pc     = m_pc;
        v.car    = m_car;
        v.e      = m_e;
        v.i      = m_i;
        v.halted = m_halt;
        due_views.insert(due_views.size(), v);
    endfunction

    // a step, preceded by loads so that it never reads a store entry never written
    function automatic void queue_step();
        logic [6:0] tgt;
        if (!m_halt && !will_halt()) begin
            if (m_mi[16:14] == F2_READ && !mem_ok[m_ar])
                push_item(REQ_LD_MEM, m_ar, 20'($urandom));
            tgt = branch_target();
            if (!cs_ok[tgt])
                push_item(REQ_LD_CS, {4'b0, tgt}, 20'($urandom));
        end
        push_item(REQ_STEP, 11'($urandom), 20'($urandom));
    endfunction

    // place a word where the next step fetches it, then step so it is latched
    function automatic void run_word(logic [19:0] w);
        push_item(REQ_LD_CS, {4'b0, branch_target()}, w);
        queue_step();
    endfunction

    // ---------------------------------------------------------------
    // mismatch reporting
    // ---------------------------------------------------------------

    task automatic report(string what);
        $display("[%0t] mismatch: %s", $time, what);
        n_bad++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // ---------------------------------------------------------------
    // stimulus generation, reset and end of run
    // ---------------------------------------------------------------

    initial begin : main
        logic [19:0] w;
        logic [10:0] a;
        int          r;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_LD_CS;
        m_axis_tready = 1'b0;
        rx_hold       = 1'b0;
        in_fire       = 1'b0;
        cycles        = 0;
        n_bad         = 0;
        n_taken       = 0;
        n_real        = 0;
        n_steps       = 0;
        n_loads       = 0;
        n_resets      = 0;
        n_halts       = 0;
        for (int k = 0; k < 128; k++)
            cs_ok[k] = 1'b0;
        for (int k = 0; k < 2048; k++)
            mem_ok[k] = 1'b0;
        machine_clear();

        // directed part: extremes, every field code, wraps, halt and reset
        push_item(REQ_RESET, 11'h7FF, 20'hFFFFF);
        push_item(REQ_LD_MEM, 11'd0, 20'hFFFFF);
        push_item(REQ_LD_MEM, 11'h7FF, 20'h00000);
        push_item(REQ_LD_CS, 11'd128, 20'hFFFFF);     // out of range, ignored
        run_word(uword(F1_NOP,   F2_READ,  F3_NOP,   CD_U, BR_JMP,  7'd10));
        run_word(uword(F1_DRTAC, F2_INCDR, F3_INCPC, CD_Z, BR_CALL, 7'd20));
        run_word(uword(F1_INCAC, F2_ACTDR, F3_SHL,   CD_S, BR_JMP,  7'd30));
        run_word(uword(F1_ADD,   F2_SUB,   F3_SHR,   CD_I, BR_RET,  7'd0));
        run_word(uword(F1_CLRAC, F2_OR,    F3_XOR,   CD_U, BR_MAP,  7'd0));
        run_word(uword(F1_PCTAR, F2_AND,   F3_COM,   CD_U, BR_JMP,  7'd127));
        run_word(uword(F1_WRITE, F2_PCTDR, F3_ARTPC, CD_S, BR_CALL, 7'd5));
        run_word(uword(F1_NOP,   F2_READ,  F3_NOP7,  CD_U, BR_JMP,  7'd1));
        // the read above picks up a word whose low address bits are all ones
        push_item(REQ_LD_MEM, m_ar, 20'hF87FF);
        run_word(uword(F1_DRTAR, F2_NOP,   F3_NOP,   CD_U, BR_JMP,  7'd0));
        queue_step();                                  // stops the machine
        queue_step();                                  // ignored while stopped
        push_item(REQ_LD_CS, 11'h7FF, 20'h12345);      // out of range, ignored
        push_item(REQ_RESET, '0, '0);

        // random part: mostly steps through random microcode, loads and resets mixed in
        while (n_real < ITEM_GOAL) begin
            r = $urandom_range(0, 99);
            if (r < 68) begin
                queue_step();
            end else if (r < 82) begin
                a = ($urandom_range(0, 3) == 0) ? m_ar : 11'($urandom);
                w = 20'($urandom);
                if ($urandom_range(0, 15) == 0)
                    w[10:0] = 11'h7FF;                 // lets DRTAR stop the machine
                push_item(REQ_LD_MEM, a, w);
            end else if (r < 96) begin
                a = ($urandom_range(0, 7) == 0) ? 11'($urandom) : 11'($urandom_range(0, 127));
                push_item(REQ_LD_CS, a, 20'($urandom));
            end else begin
                push_item(REQ_RESET, 11'($urandom), 20'($urandom));
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (due_views.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("run covered %0d requests: %0d steps, %0d loads, %0d resets",
                 n_steps + n_loads + n_resets, n_steps, n_loads, n_resets);
        $display("machine stopped by an all-ones address %0d times", n_halts);
        if (n_bad == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------
    // driver: request channel and result-side ready, both at the falling edge
    // ---------------------------------------------------------------

    always @(negedge i_clk) begin : drive
        t_req_item nxt;
        if (i_rst_n) begin
            // offer the next item once the current one has gone in
            if (!s_axis_tvalid || in_fire) begin
                if (req_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
                    nxt = req_backlog[0];
                    req_backlog.delete(0);
                    s_axis_tdata  <= {1'b0, nxt.data, nxt.addr};
                    s_axis_tuser  <= nxt.kind;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= !rx_hold && (calm || $urandom_range(0, 99) >= 10);
        end
    end

    // handshake on the request channel as seen at the rising edge
    always @(posedge i_clk) begin
        in_fire <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
            n_taken <= n_taken + 1;
    end

    // long receiver stall while requests keep coming, so the input backs up
    initial begin : hold_off
        wait (n_taken >= 300);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // ---------------------------------------------------------------
    // monitor: every accepted result against the oldest expectation
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin : watch
        t_cpu_view want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_views.size() == 0) begin
                report($sformatf("result item with nothing expected, data %h", m_axis_tdata));
            end else begin
                want = due_views[0];
                due_views.delete(0);
                check_field("ac",     m_axis_tdata[15:0],  want.ac);
                check_field("dr",     m_axis_tdata[31:16], want.dr);
                check_field("ar",     m_axis_tdata[42:32], want.ar);
                check_field("pc",     m_axis_tdata[53:43], want.pc);
                check_field("car",    m_axis_tdata[60:54], want.car);
                check_field("e",      m_axis_tdata[61],    want.e);
                check_field("i",      m_axis_tdata[62],    want.i);
                check_field("halted", m_axis_tdata[63],    want.halted);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, due_views.size());
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
src/mbc_pkg.sv
src/mbc_seq.sv
src/microprogrammed_basic_computer_unit.sv
sim/testbench.sv
